>>> sv/knps_pkg.sv
package knps_pkg;

  localparam int MAX_K_DEF      = 16;
  localparam int INDEX_BITS_DEF = 20;
  localparam int COORD_BITS     = 16;
  localparam int OUT_INDEX_W    = 20;
  localparam int OUT_DIST_W     = 17;
  localparam int CFG_ADDR_W     = 5;

  localparam logic [2:0] REG_QUERY_X = 3'd0;
  localparam logic [2:0] REG_QUERY_Y = 3'd1;
  localparam logic [2:0] REG_QUERY_Z = 3'd2;
  localparam logic [2:0] REG_DIMS    = 3'd3;
  localparam logic [2:0] REG_K_COUNT = 3'd4;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] coord_x;
    logic signed [COORD_BITS-1:0] coord_y;
    logic signed [COORD_BITS-1:0] coord_z;
    logic                         last_point;
  } in_word_t;

  typedef struct packed {
    logic [OUT_INDEX_W-1:0] point_index;
    logic [OUT_DIST_W-1:0]  distance;
    logic                   count_overflow;
    logic                   last_result;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIFF, ST_SQ, ST_SUM, ST_INSERT, ST_SQRT, ST_ROOT, ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic diff;
    logic square;
    logic sum;
    logic insert;
    logic sqrt_start;
    logic sqrt_step;
    logic emit_next;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic last_point;
    logic sqrt_done;
    logic emit_last;
  } status_t;

endpackage

>>> sv/k_nearest_point_select.sv
// Channel | Direction | Handshake              | Word
// in      | input     | in_valid / in_stall    | knps_pkg::in_word_t
// out     | output    | out_valid / out_stall  | knps_pkg::out_word_t
// cfg     | input     | APB psel/penable/pready | 32-bit registers
// Each point passes in turn through load, difference, square, sum and sorted insert.
// A last point then gives the results one by one while out_stall is low: the entry
// is fetched, 17 square root steps are made and the word is presented.
// Reset is synchronous and clears the list count, index counter and overflow flag.
// Input is stalled while results are being sent.
module k_nearest_point_select #(
  parameter int MAX_K      = knps_pkg::MAX_K_DEF,
  parameter int INDEX_BITS = knps_pkg::INDEX_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  knps_pkg::in_word_t                  in_word,
  output logic                                out_valid,
  input  logic                                out_stall,
  output knps_pkg::out_word_t                 out_word,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [knps_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [31:0]                         cfg_pwdata,
  output logic [31:0]                         cfg_prdata,
  output logic                                cfg_pready
);

  logic [knps_pkg::COORD_BITS-1:0] query_x_r, query_y_r, query_z_r;
  logic [1:0]  dims_r;
  logic [4:0]  k_count_r;
  logic [2:0]  reg_sel;

  knps_pkg::cmd_t    cmd;
  knps_pkg::status_t status;

  assign cfg_pready = 1'b1;
  assign reg_sel    = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      query_x_r <= '0;
      query_y_r <= '0;
      query_z_r <= '0;
      dims_r    <= 2'd3;
      k_count_r <= 5'd1;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[1:0] == 2'b00) begin
      unique case (reg_sel)
        knps_pkg::REG_QUERY_X: query_x_r <= cfg_pwdata[knps_pkg::COORD_BITS-1:0];
        knps_pkg::REG_QUERY_Y: query_y_r <= cfg_pwdata[knps_pkg::COORD_BITS-1:0];
        knps_pkg::REG_QUERY_Z: query_z_r <= cfg_pwdata[knps_pkg::COORD_BITS-1:0];
        knps_pkg::REG_DIMS:    dims_r    <= cfg_pwdata[1:0];
        knps_pkg::REG_K_COUNT: k_count_r <= cfg_pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      knps_pkg::REG_QUERY_X: cfg_prdata = 32'(query_x_r);
      knps_pkg::REG_QUERY_Y: cfg_prdata = 32'(query_y_r);
      knps_pkg::REG_QUERY_Z: cfg_prdata = 32'(query_z_r);
      knps_pkg::REG_DIMS:    cfg_prdata = {30'd0, dims_r};
      knps_pkg::REG_K_COUNT: cfg_prdata = {27'd0, k_count_r};
      default:               cfg_prdata = '0;
    endcase
  end

  knps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  knps_datapath #(
    .MAX_K      (MAX_K),
    .INDEX_BITS (INDEX_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_word),
    .query_x  (query_x_r),
    .query_y  (query_y_r),
    .query_z  (query_z_r),
    .dims     (dims_r),
    .k_count  (k_count_r),
    .cmd      (cmd),
    .status   (status),
    .out_word (out_word)
  );

endmodule

>>> sv/knps_datapath.sv
module knps_datapath #(
  parameter int MAX_K      = knps_pkg::MAX_K_DEF,
  parameter int INDEX_BITS = knps_pkg::INDEX_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  knps_pkg::in_word_t              in_word,
  input  logic [knps_pkg::COORD_BITS-1:0] query_x,
  input  logic [knps_pkg::COORD_BITS-1:0] query_y,
  input  logic [knps_pkg::COORD_BITS-1:0] query_z,
  input  logic [1:0]                      dims,
  input  logic [4:0]                      k_count,
  input  knps_pkg::cmd_t                  cmd,
  output knps_pkg::status_t               status,
  output knps_pkg::out_word_t             out_word
);

  localparam int COORD_BITS = knps_pkg::COORD_BITS;
  localparam int DW  = COORD_BITS + 1;
  localparam int SQW = 2 * DW;
  localparam int DSW = 2 * COORD_BITS + 2;
  localparam int KW  = $clog2(MAX_K + 1);
  localparam int PW  = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int RW  = DSW / 2 + 1;
  localparam int SW  = DSW / 2 + (DSW % 2);
  localparam int STW = $clog2(SW + 1);

  logic signed [COORD_BITS-1:0] cx_r, cy_r, cz_r;
  logic                         last_r;
  logic [DW-1:0]                ax_r, ay_r, az_r;
  logic [SQW-1:0]               sx_r, sy_r, sz_r;
  logic [DSW-1:0]               dsq_r;
  logic [INDEX_BITS-1:0]        idx_r, next_index_r;
  logic                         ovf_r;
  logic [KW-1:0]                cnt_r, emit_r;
  logic [DSW-1:0]               kd_r [MAX_K];
  logic [INDEX_BITS-1:0]        ki_r [MAX_K];
  logic [DSW-1:0]               src_r;
  logic [RW+1:0]                rem_r;
  logic [RW-1:0]                root_r;
  logic [STW-1:0]               step_r;

  logic [KW-1:0] k_eff;
  logic [KW-1:0] cnt_t;
  logic [1:0]    nd;

  always_comb begin
    if (k_count == 5'd0) k_eff = KW'(1);
    else if (32'(k_count) > MAX_K) k_eff = KW'(MAX_K);
    else k_eff = KW'(k_count);
    cnt_t = (cnt_r > k_eff) ? k_eff : cnt_r;
    nd = (dims == 2'd0) ? 2'd1 : dims;
  end

  function automatic logic [DW-1:0] absdiff(input logic signed [COORD_BITS-1:0] a,
                                            input logic [COORD_BITS-1:0] q);
    logic signed [DW-1:0] d;
    d = DW'(a) - DW'($signed(q));
    absdiff = d[DW-1] ? DW'(-d) : DW'(d);
  endfunction

  logic accept_new;
  logic [DSW-1:0] tail_d;
  always_comb begin
    tail_d = kd_r[PW'(cnt_t - KW'(1))];
    accept_new = (cnt_t < k_eff) || (dsq_r < tail_d);
  end

  logic [KW-1:0] cnt_new;
  assign cnt_new = (cnt_t < k_eff) ? cnt_t + KW'(1) : cnt_t;

  logic [MAX_K-1:0] gt, gt_prev;
  always_comb begin
    for (int i = 0; i < MAX_K; i++) gt[i] = kd_r[i] > dsq_r;
    gt_prev = MAX_K'({gt, 1'b0});
  end

  logic [RW+1:0] r2, cand;
  logic          fits;
  assign r2   = {rem_r[RW-1:0], src_r[DSW-1:DSW-2]};
  assign cand = {root_r, 2'b01};
  assign fits = (r2 >= cand);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      next_index_r <= '0;
      ovf_r        <= 1'b0;
      emit_r       <= '0;
      step_r       <= '0;
    end else begin
      if (cmd.load) begin
        cx_r   <= in_word.coord_x;
        cy_r   <= in_word.coord_y;
        cz_r   <= in_word.coord_z;
        last_r <= in_word.last_point;
        idx_r  <= next_index_r;
        if (&next_index_r) ovf_r <= 1'b1;
        else next_index_r <= next_index_r + INDEX_BITS'(1);
      end
      if (cmd.diff) begin
        ax_r <= absdiff(cx_r, query_x);
        ay_r <= (nd >= 2'd2) ? absdiff(cy_r, query_y) : '0;
        az_r <= (nd == 2'd3) ? absdiff(cz_r, query_z) : '0;
      end
      if (cmd.square) begin
        sx_r <= ax_r * ax_r;
        sy_r <= ay_r * ay_r;
        sz_r <= az_r * az_r;
      end
      if (cmd.sum) dsq_r <= DSW'(sx_r) + DSW'(sy_r) + DSW'(sz_r);
      if (cmd.insert) begin
        cnt_r <= accept_new ? cnt_new : cnt_t;
        if (accept_new) begin
          for (int i = 1; i < MAX_K; i++) begin
            if (KW'(i) < cnt_new && gt_prev[i]) begin
              kd_r[i] <= kd_r[i-1];
              ki_r[i] <= ki_r[i-1];
            end
          end
          for (int i = 0; i < MAX_K; i++) begin
            if (KW'(i) < cnt_new && !gt_prev[i] &&
                ((KW'(i) == cnt_new - KW'(1)) || gt[i])) begin
              kd_r[i] <= dsq_r;
              ki_r[i] <= idx_r;
            end
          end
        end
        emit_r <= '0;
      end
      if (cmd.sqrt_start) begin
        src_r  <= kd_r[PW'(emit_r)];
        rem_r  <= '0;
        root_r <= '0;
        step_r <= '0;
      end
      if (cmd.sqrt_step) begin
        src_r  <= {src_r[DSW-3:0], 2'b00};
        rem_r  <= fits ? r2 - cand : r2;
        root_r <= {root_r[RW-2:0], fits};
        step_r <= step_r + STW'(1);
      end
      if (cmd.emit_next) emit_r <= emit_r + KW'(1);
      if (cmd.clear) begin
        cnt_r        <= '0;
        next_index_r <= '0;
        ovf_r        <= 1'b0;
      end
    end
  end

  assign status.last_point = last_r;
  assign status.sqrt_done  = (step_r == STW'(SW - 1));
  assign status.emit_last  = (emit_r + KW'(1) >= cnt_r);

  assign out_word.point_index    = knps_pkg::OUT_INDEX_W'(ki_r[PW'(emit_r)]);
  assign out_word.distance       = knps_pkg::OUT_DIST_W'(root_r);
  assign out_word.count_overflow = ovf_r;
  assign out_word.last_result    = status.emit_last;

endmodule

>>> sv/knps_ctrl.sv
module knps_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  output logic                    out_valid,
  input  logic                    out_stall,
  input  knps_pkg::status_t       status,
  output knps_pkg::cmd_t          cmd
);

  knps_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= knps_pkg::ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      knps_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = knps_pkg::ST_DIFF;
        end
      end
      knps_pkg::ST_DIFF: begin
        cmd.diff  = 1'b1;
        state_nxt = knps_pkg::ST_SQ;
      end
      knps_pkg::ST_SQ: begin
        cmd.square = 1'b1;
        state_nxt  = knps_pkg::ST_SUM;
      end
      knps_pkg::ST_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = knps_pkg::ST_INSERT;
      end
      knps_pkg::ST_INSERT: begin
        cmd.insert = 1'b1;
        state_nxt  = status.last_point ? knps_pkg::ST_SQRT : knps_pkg::ST_IDLE;
      end
      knps_pkg::ST_SQRT: begin
        cmd.sqrt_start = 1'b1;
        state_nxt      = knps_pkg::ST_ROOT;
      end
      knps_pkg::ST_ROOT: begin
        cmd.sqrt_step = 1'b1;
        if (status.sqrt_done) state_nxt = knps_pkg::ST_EMIT;
      end
      knps_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          if (status.emit_last) begin
            cmd.clear = 1'b1;
            state_nxt = knps_pkg::ST_IDLE;
          end else begin
            cmd.emit_next = 1'b1;
            state_nxt     = knps_pkg::ST_SQRT;
          end
        end
      end
      default: state_nxt = knps_pkg::ST_IDLE;
    endcase
  end

endmodule
